[hw/rtl/hs_pkg.sv]
package hs_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = CNT_W + 1;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [WIDTH-1:0] word_t;

    localparam word_t SIGN_MASK = word_t'(1) << (WIDTH - 1);

    typedef struct packed {
        logic signed [WIDTH-1:0] value;
        logic                    last;
    } in_word_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] sorted_value;
        logic                    end_of_run;
        logic                    overflow;
    } out_word_t;

    // One classified input word on its way to the back end.
    typedef struct packed {
        word_t            value;
        logic [AW-1:0]    addr;
        logic [CNT_W-1:0] n;
        logic             store;
        logic             last;
        logic             ovf;
    } hs_entry_t;

    // Signed greater-than through an offset-binary key.
    function automatic logic key_gt(word_t a, word_t b);
        return (a ^ SIGN_MASK) > (b ^ SIGN_MASK);
    endfunction

endpackage

[hw/rtl/hs_front.sv]
module hs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  hs_pkg::in_word_t item,
    output logic             push_valid,
    input  logic             push_ready,
    output hs_pkg::hs_entry_t push_data
);
    import hs_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drop_reg;
    logic             drop_next;
    logic             has_room;
    logic             fire;

    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign fire       = item_valid && push_ready;
    assign has_room   = count_reg < CNT_W'(DEPTH);

    always_comb
    begin
        push_data.value = word_t'(item.value);
        push_data.addr  = count_reg[AW-1:0];
        push_data.n     = has_room ? CNT_W'(count_reg + 1'b1) : count_reg;
        push_data.store = has_room;
        push_data.last  = item.last;
        push_data.ovf   = drop_reg || !has_room;
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (fire)
        begin
            // close the set: start the next one empty
            if (item.last)
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
            else if (has_room)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

[hw/rtl/hs_queue.sv]
module hs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  hs_pkg::hs_entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output hs_pkg::hs_entry_t pop_data
);
    import hs_pkg::*;

    hs_entry_t      slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   fill_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = fill_reg != (QAW+1)'(QDEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= QAW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QAW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= (QAW+1)'(fill_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= (QAW+1)'(fill_reg - 1'b1);
            end
        end
    end

endmodule

[hw/rtl/hs_back.sv]
module hs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  hs_pkg::hs_entry_t pop_data,
    output logic              result_valid,
    input  logic              result_ready,
    output hs_pkg::out_word_t result
);
    import hs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_RD,
        S_EXT,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    word_t heap_mem [DEPTH];

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] n_reg,         n_next;
    logic             ovf_reg,       ovf_next;
    logic [CNT_W-1:0] bld_reg,       bld_next;
    logic [CNT_W-1:0] ext_reg,       ext_next;
    logic [CNT_W-1:0] size_reg,      size_next;
    logic [CNT_W-1:0] pos_reg,       pos_next;
    logic [CNT_W-1:0] k_reg,         k_next;
    logic             build_reg,     build_next;
    word_t            cur_reg,       cur_next;
    out_word_t        out_reg,       out_next;
    logic             out_valid_reg, out_valid_next;

    word_t         rd_a_reg;
    word_t         rd_b_reg;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    word_t         mem_wdata;

    logic [POS_W-1:0] lpos;
    logic [POS_W-1:0] rpos;
    logic [POS_W-1:0] size_ext;
    logic [POS_W-1:0] big_pos;
    word_t            big_val;
    logic             sift_done;
    logic [AW-1:0]    pos_addr;

    assign lpos     = POS_W'({pos_reg, 1'b0});
    assign rpos     = POS_W'(lpos + 1'b1);
    assign size_ext = POS_W'(size_reg);
    assign pos_addr = AW'(pos_reg - 1'b1);

    assign pop_ready    = state_reg == S_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        big_val = cur_reg;
        big_pos = POS_W'(pos_reg);
        if (key_gt(rd_a_reg, cur_reg))
        begin
            big_val = rd_a_reg;
            big_pos = lpos;
        end
        if (rpos <= size_ext && key_gt(rd_b_reg, big_val))
        begin
            big_val = rd_b_reg;
            big_pos = rpos;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        bld_next       = bld_reg;
        ext_next       = ext_reg;
        size_next      = size_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        build_next     = build_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        rd_a_addr      = '0;
        rd_b_addr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = pos_addr;
        mem_wdata      = cur_reg;
        sift_done      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    mem_we    = pop_data.store;
                    mem_waddr = pop_data.addr;
                    mem_wdata = pop_data.value;
                    if (pop_data.last)
                    begin
                        n_next    = pop_data.n;
                        ovf_next  = pop_data.ovf;
                        k_next    = '0;
                        bld_next  = pop_data.n >> 1;
                        build_next = 1'b1;
                        if ((pop_data.n >> 1) != '0)
                        begin
                            state_next = S_LOAD_RD;
                        end
                        else
                        begin
                            state_next = S_OUT_RD;
                        end
                    end
                end
            end
            S_LOAD_RD:
            begin
                rd_a_addr  = AW'(bld_reg - 1'b1);
                pos_next   = bld_reg;
                size_next  = n_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cur_next   = rd_a_reg;
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                if (lpos > size_ext)
                begin
                    // no children left: drop the carried value into the hole
                    mem_we    = 1'b1;
                    sift_done = 1'b1;
                end
                else
                begin
                    rd_a_addr  = AW'(lpos - 1'b1);
                    rd_b_addr  = AW'(rpos - 1'b1);
                    state_next = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP:
            begin
                mem_we = 1'b1;
                if (big_pos == POS_W'(pos_reg))
                begin
                    sift_done = 1'b1;
                end
                else
                begin
                    // move the larger child up and follow it
                    mem_wdata  = big_val;
                    pos_next   = CNT_W'(big_pos);
                    state_next = S_SIFT_RD;
                end
            end
            S_EXT_RD:
            begin
                rd_a_addr  = '0;
                rd_b_addr  = AW'(ext_reg - 1'b1);
                build_next = 1'b0;
                state_next = S_EXT;
            end
            S_EXT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(ext_reg - 1'b1);
                mem_wdata  = rd_a_reg;
                cur_next   = rd_b_reg;
                pos_next   = CNT_W'(1);
                size_next  = CNT_W'(ext_reg - 1'b1);
                state_next = S_SIFT_RD;
            end
            S_OUT_RD:
            begin
                rd_a_addr = k_reg[AW-1:0];
                if (!out_valid_reg || result_ready)
                begin
                    state_next = S_OUT_LD;
                end
            end
            S_OUT_LD:
            begin
                out_next.sorted_value = rd_a_reg;
                out_next.end_of_run   = k_reg == CNT_W'(n_reg - 1'b1);
                out_next.overflow     = ovf_reg;
                out_valid_next        = 1'b1;
                if (k_reg == CNT_W'(n_reg - 1'b1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = CNT_W'(k_reg + 1'b1);
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (sift_done)
        begin
            if (build_reg)
            begin
                if (bld_reg == CNT_W'(1))
                begin
                    ext_next   = n_reg;
                    state_next = (n_reg >= CNT_W'(2)) ? S_EXT_RD : S_OUT_RD;
                end
                else
                begin
                    bld_next   = CNT_W'(bld_reg - 1'b1);
                    state_next = S_LOAD_RD;
                end
            end
            else
            begin
                if (ext_reg == CNT_W'(2))
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    ext_next   = CNT_W'(ext_reg - 1'b1);
                    state_next = S_EXT_RD;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            bld_reg       <= '0;
            ext_reg       <= '0;
            size_reg      <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            bld_reg       <= bld_next;
            ext_reg       <= ext_next;
            size_reg      <= size_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            out_reg       <= out_next;
        end
    end

endmodule

[hw/rtl/heap_sorter_top.sv]
// Heap sorter. Words of signed values stream in on the item channel; the word
// with last set closes a set of up to DEPTH values (later ones are dropped and
// every result of that set carries overflow). The set is then heap-sorted in a
// single-ported-write, dual-read memory and streamed out in ascending order,
// end_of_run marking the final word. The back end loads one word per cycle
// while it is idle; a four-entry queue takes up to four words of the next set
// while the back end sorts, after which the item channel stalls until the back
// end is idle again. Sorting is bounded by the read state and the compare state
// of each sift level against the heap memory; output then alternates a read
// state and a load state for each word, and holds while result_ready is low.
module heap_sorter_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  hs_pkg::in_word_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output hs_pkg::out_word_t result
);
    import hs_pkg::*;

    logic      push_valid;
    logic      push_ready;
    hs_entry_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    hs_entry_t pop_data;

    hs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[hw/rtl/hs_checker.sv]
module hs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input hs_pkg::in_word_t  item,
    input logic              result_valid,
    input logic              result_ready,
    input hs_pkg::out_word_t result
);
    import hs_pkg::*;

    logic  out_fire;
    logic  in_fire;
    logic  open_reg;
    word_t prev_val_reg;
    logic  prev_ovf_reg;

    assign out_fire = result_valid && result_ready;
    assign in_fire  = item_valid && item_ready;

    // track the previous accepted word of the run in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            prev_val_reg <= '0;
            prev_ovf_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            open_reg     <= !result.end_of_run;
            prev_val_reg <= word_t'(result.sorted_value);
            prev_ovf_reg <= result.overflow;
        end
    end

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && open_reg |->
            !key_gt(prev_val_reg, word_t'(result.sorted_value)))
        else $error("results out of ascending order");

    a_overflow_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && open_reg |-> result.overflow == prev_ovf_reg)
        else $error("overflow flag changed within a run");

    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !$isunknown(item.last))
        else $error("accepted word with unknown last flag");

endmodule

bind heap_sorter_top hs_checker u_hs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
